[design/rgbap_pkg.sv]
// Shared constants, types and the division step helper for the RGBA alpha premultiply unit.
package rgbap_pkg;

	localparam int NUM_STAGES = 5;

	localparam logic [7:0] CHAN_MAX  = 8'd255;
	localparam logic [7:0] CEIL_BIAS = 8'd254;

	// floor(x / 255) == (x * RECIP_255) >> RECIP_SHIFT for x below 65536
	localparam logic [15:0] RECIP_255   = 16'd32897;
	localparam int          RECIP_SHIFT = 23;

	localparam logic [1:0] ACT_FLOOR  = 2'd0;
	localparam logic [1:0] ACT_CEIL   = 2'd1;
	localparam logic [1:0] ACT_UNPREM = 2'd2;

	localparam logic [1:0] MODE_PASS   = 2'd0;
	localparam logic [1:0] MODE_FLOOR  = 2'd1;
	localparam logic [1:0] MODE_CEIL   = 2'd2;
	localparam logic [1:0] MODE_UNPREM = 2'd3;

	typedef logic [7:0] chan_t;

	typedef struct packed {
		logic [NUM_STAGES:1] adv;
	} pipe_ctl_t;

	typedef struct packed {
		logic [15:0] rem;
		logic        qbit;
	} div_step_t;

	// one restoring division step against the divisor shifted left by sh
	function automatic div_step_t div_step(input logic [15:0] rem, input chan_t dvs,
			input logic [2:0] sh);
		logic [15:0] dsh;
		div_step_t   r;
		dsh = {8'b0, dvs} << sh;
		if (rem >= dsh) begin
			r.rem  = rem - dsh;
			r.qbit = 1'b1;
		end else begin
			r.rem  = rem;
			r.qbit = 1'b0;
		end
		return r;
	endfunction

endpackage

[design/rgba_alpha_premultiply_unit.sv]
// Top level of the RGBA alpha premultiply / unpremultiply unit.
// Usage:
//   Input channel (in_valid, in_stall, action, red_in, green_in, blue_in, alpha_in)
//   takes one pixel word; action selects floor premultiply, ceiling premultiply
//   or unpremultiply. Pixels with alpha 0 or 255, and the unused action code,
//   pass through unchanged; alpha always passes through.
//   Output channel (out_valid, out_stall, red_out, green_out, blue_out, alpha_out)
//   returns one converted word per input word, in order.
// An accepted word moves through the stages in order; out_valid is the valid
//   bit of the last stage, and the word leaves at an edge with out_stall low.
// Throughput: one word per cycle while out_stall is low. Premultiply is one 8x8
//   product and a reciprocal multiply; unpremultiply is a restoring divider
//   retiring two quotient bits per stage over four stages, which sets the depth.
// Reset: arst_n clears all stage valid bits; the pipeline comes up empty.
// Stall: a stalled output word holds; earlier stages keep filling empty slots
//   and in_stall rises only once all five stages hold words.
module rgba_alpha_premultiply_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] action,
	input  logic [7:0] red_in,
	input  logic [7:0] green_in,
	input  logic [7:0] blue_in,
	input  logic [7:0] alpha_in,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] red_out,
	output logic [7:0] green_out,
	output logic [7:0] blue_out,
	output logic [7:0] alpha_out
);

	rgbap_pkg::pipe_ctl_t ctl;
	logic [rgbap_pkg::NUM_STAGES:1] vld;

	rgbap_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.alpha_in  (alpha_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.alpha_out (alpha_out),
		.ctl       (ctl),
		.vld       (vld)
	);

	rgbap_chan u_red (
		.clk    (clk),
		.ctl    (ctl),
		.action (action),
		.c_in   (red_in),
		.a_in   (alpha_in),
		.c_out  (red_out)
	);

	rgbap_chan u_green (
		.clk    (clk),
		.ctl    (ctl),
		.action (action),
		.c_in   (green_in),
		.a_in   (alpha_in),
		.c_out  (green_out)
	);

	rgbap_chan u_blue (
		.clk    (clk),
		.ctl    (ctl),
		.action (action),
		.c_in   (blue_in),
		.a_in   (alpha_in),
		.c_out  (blue_out)
	);

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (&vld))
		else $error("input stalled while a stage is empty");

	a_stall_needs_out_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a stalled output word");

	a_fill_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> vld[1])
		else $error("accepted word missing from first stage");

endmodule

[design/rgbap_ctl.sv]
// Pipeline control: stage valid bits, advance enables and the alpha delay line.
module rgbap_ctl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  rgbap_pkg::chan_t     alpha_in,
	output logic                 out_valid,
	input  logic                 out_stall,
	output rgbap_pkg::chan_t     alpha_out,
	output rgbap_pkg::pipe_ctl_t ctl,
	output logic [rgbap_pkg::NUM_STAGES:1] vld
);

	logic [rgbap_pkg::NUM_STAGES:1] vld_q;
	logic [rgbap_pkg::NUM_STAGES:1] adv;
	rgbap_pkg::chan_t alpha_s1, alpha_s2, alpha_s3, alpha_s4, alpha_s5;

	// advance a stage when it is empty or the next one moves
	always_comb begin
		adv[rgbap_pkg::NUM_STAGES] = !vld_q[rgbap_pkg::NUM_STAGES] || !out_stall;
		for (int k = rgbap_pkg::NUM_STAGES - 1; k >= 1; k--) begin
			adv[k] = !vld_q[k] || adv[k + 1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int k = 2; k <= rgbap_pkg::NUM_STAGES; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k - 1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1]) alpha_s1 <= alpha_in;
		if (adv[2]) alpha_s2 <= alpha_s1;
		if (adv[3]) alpha_s3 <= alpha_s2;
		if (adv[4]) alpha_s4 <= alpha_s3;
		if (adv[5]) alpha_s5 <= alpha_s4;
	end

	assign in_stall  = !adv[1];
	assign out_valid = vld_q[rgbap_pkg::NUM_STAGES];
	assign alpha_out = alpha_s5;
	assign ctl.adv   = adv;
	assign vld       = vld_q;

endmodule

[design/rgbap_chan.sv]
// Datapath of one colour channel: premultiply by reciprocal, unpremultiply by restoring division.
module rgbap_chan (
	input  logic                 clk,
	input  rgbap_pkg::pipe_ctl_t ctl,
	input  logic [1:0]           action,
	input  rgbap_pkg::chan_t     c_in,
	input  rgbap_pkg::chan_t     a_in,
	output rgbap_pkg::chan_t     c_out
);

	logic [1:0]       mode_n;
	logic [15:0]      bias_n;
	logic [31:0]      prod_n;
	rgbap_pkg::div_step_t d2a, d2b, d3a, d3b, d4a, d4b, d5a, d5b;

	logic [1:0]       mode_s1, mode_s2, mode_s3, mode_s4;
	rgbap_pkg::chan_t c_s1, c_s2, c_s3, c_s4;
	rgbap_pkg::chan_t a_s1, a_s2, a_s3, a_s4;
	logic             sat_s1, sat_s2, sat_s3, sat_s4;
	logic [15:0]      p_s1;
	logic [15:0]      m_s1, rem_s2, rem_s3, rem_s4;
	rgbap_pkg::chan_t pm_s2, pm_s3, pm_s4;
	logic [7:0]       q_s2, q_s3, q_s4;
	rgbap_pkg::chan_t res_s5;

	always_comb begin
		if (a_in == 8'd0 || a_in == rgbap_pkg::CHAN_MAX) begin
			mode_n = rgbap_pkg::MODE_PASS;
		end else begin
			case (action)
				rgbap_pkg::ACT_FLOOR:  mode_n = rgbap_pkg::MODE_FLOOR;
				rgbap_pkg::ACT_CEIL:   mode_n = rgbap_pkg::MODE_CEIL;
				rgbap_pkg::ACT_UNPREM: mode_n = rgbap_pkg::MODE_UNPREM;
				default:               mode_n = rgbap_pkg::MODE_PASS;
			endcase
		end
		bias_n = (mode_n == rgbap_pkg::MODE_CEIL) ? {8'b0, rgbap_pkg::CEIL_BIAS} : 16'd0;
	end

	always_comb begin
		prod_n = 32'(p_s1) * 32'(rgbap_pkg::RECIP_255);
		d2a = rgbap_pkg::div_step(m_s1, a_s1, 3'd7);
		d2b = rgbap_pkg::div_step(d2a.rem, a_s1, 3'd6);
		d3a = rgbap_pkg::div_step(rem_s2, a_s2, 3'd5);
		d3b = rgbap_pkg::div_step(d3a.rem, a_s2, 3'd4);
		d4a = rgbap_pkg::div_step(rem_s3, a_s3, 3'd3);
		d4b = rgbap_pkg::div_step(d4a.rem, a_s3, 3'd2);
		d5a = rgbap_pkg::div_step(rem_s4, a_s4, 3'd1);
		d5b = rgbap_pkg::div_step(d5a.rem, a_s4, 3'd0);
	end

	always_ff @(posedge clk) begin
		if (ctl.adv[1]) begin
			mode_s1 <= mode_n;
			c_s1    <= c_in;
			a_s1    <= a_in;
			sat_s1  <= c_in > a_in;
			p_s1    <= ({8'b0, c_in} * {8'b0, a_in}) + bias_n;
			m_s1    <= ({c_in, 8'b0} - {8'b0, c_in}) + {8'b0, a_in} - 16'd1;
		end
		if (ctl.adv[2]) begin
			mode_s2 <= mode_s1;
			c_s2    <= c_s1;
			a_s2    <= a_s1;
			sat_s2  <= sat_s1;
			pm_s2   <= prod_n[rgbap_pkg::RECIP_SHIFT +: 8];
			rem_s2  <= d2b.rem;
			q_s2    <= {d2a.qbit, d2b.qbit, 6'b0};
		end
		if (ctl.adv[3]) begin
			mode_s3 <= mode_s2;
			c_s3    <= c_s2;
			a_s3    <= a_s2;
			sat_s3  <= sat_s2;
			pm_s3   <= pm_s2;
			rem_s3  <= d3b.rem;
			q_s3    <= {q_s2[7:6], d3a.qbit, d3b.qbit, 4'b0};
		end
		if (ctl.adv[4]) begin
			mode_s4 <= mode_s3;
			c_s4    <= c_s3;
			a_s4    <= a_s3;
			sat_s4  <= sat_s3;
			pm_s4   <= pm_s3;
			rem_s4  <= d4b.rem;
			q_s4    <= {q_s3[7:4], d4a.qbit, d4b.qbit, 2'b0};
		end
		if (ctl.adv[5]) begin
			case (mode_s4)
				rgbap_pkg::MODE_FLOOR,
				rgbap_pkg::MODE_CEIL:   res_s5 <= pm_s4;
				rgbap_pkg::MODE_UNPREM: res_s5 <= sat_s4 ? rgbap_pkg::CHAN_MAX :
						{q_s4[7:2], d5a.qbit, d5b.qbit};
				default:                res_s5 <= c_s4;
			endcase
		end
	end

	assign c_out = res_s5;

endmodule

[sim/rgbap_pixel_checker.sv]
// Checker for the RGBA alpha premultiply unit: predicts each pixel word and compares results.
module rgbap_pixel_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [1:0] action,
	input  logic [7:0] red_in,
	input  logic [7:0] green_in,
	input  logic [7:0] blue_in,
	input  logic [7:0] alpha_in,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [7:0] red_out,
	input  logic [7:0] green_out,
	input  logic [7:0] blue_out,
	input  logic [7:0] alpha_out,
	output int         errors,
	output int         pending
);

	typedef struct packed {
		rgbap_pkg::chan_t r;
		rgbap_pkg::chan_t g;
		rgbap_pkg::chan_t b;
		rgbap_pkg::chan_t a;
	} pixel_t;

	pixel_t pixel_q[$];
	int     mismatch_cnt = 0;

	assign errors = mismatch_cnt;

	function automatic rgbap_pkg::chan_t convert_chan(input logic [1:0] act,
			input rgbap_pkg::chan_t c, input rgbap_pkg::chan_t a);
		int unsigned cv;
		int unsigned av;
		int unsigned q;
		cv = c;
		av = a;
		if (a == 8'd0 || a == rgbap_pkg::CHAN_MAX)
			return c;
		case (act)
			rgbap_pkg::ACT_FLOOR: q = (cv * av) / rgbap_pkg::CHAN_MAX;
			rgbap_pkg::ACT_CEIL: q = (cv * av + rgbap_pkg::CEIL_BIAS) / rgbap_pkg::CHAN_MAX;
			rgbap_pkg::ACT_UNPREM: begin
				q = (cv * rgbap_pkg::CHAN_MAX + av - 1) / av;
				if (q > rgbap_pkg::CHAN_MAX)
					q = rgbap_pkg::CHAN_MAX;
			end
			default: q = cv;
		endcase
		return rgbap_pkg::chan_t'(q);
	endfunction

	task automatic report(input string msg);
		$display("%0t: %s", $time, msg);
		mismatch_cnt++;
	endtask

	task automatic check_chan(input string name, input rgbap_pkg::chan_t want,
			input rgbap_pkg::chan_t got);
		if (want !== got)
			report($sformatf("%s mismatch: expected %0d, got %0d", name, want, got));
	endtask

	always @(posedge clk) begin : watch
		pixel_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pixel_q.size() == 0) begin
					report($sformatf("unexpected word r=%0d g=%0d b=%0d a=%0d",
						red_out, green_out, blue_out, alpha_out));
				end else begin
					want = pixel_q.pop_front();
					check_chan("red", want.r, red_out);
					check_chan("green", want.g, green_out);
					check_chan("blue", want.b, blue_out);
					check_chan("alpha", want.a, alpha_out);
				end
			end
			if (in_valid && !in_stall)
				pixel_q.push_back({convert_chan(action, red_in, alpha_in),
					convert_chan(action, green_in, alpha_in),
					convert_chan(action, blue_in, alpha_in), alpha_in});
			pending <= pixel_q.size();
		end
	end

endmodule

[sim/tb.sv]
// Testbench top for the RGBA alpha premultiply unit: reset, stimulus, flow control and verdict.
module tb;

	localparam logic [1:0] ACT_SPARE = 2'd3;
	localparam int RANDOM_WORDS = 800;
	localparam int LONG_HOLD = 80;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       out_stall = 1'b0;
	logic [1:0] action = rgbap_pkg::ACT_FLOOR;
	logic [7:0] red_in = '0;
	logic [7:0] green_in = '0;
	logic [7:0] blue_in = '0;
	logic [7:0] alpha_in = '0;
	logic       in_stall;
	logic       out_valid;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;
	logic [7:0] alpha_out;
	int         errors;
	int         pending;
	bit         send_burst = 1'b0;
	bit         sink_burst = 1'b0;
	int         sunk = 0;

	always #2 clk = ~clk;

	rgba_alpha_premultiply_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.red_in(red_in),
		.green_in(green_in),
		.blue_in(blue_in),
		.alpha_in(alpha_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.red_out(red_out),
		.green_out(green_out),
		.blue_out(blue_out),
		.alpha_out(alpha_out)
	);

	rgbap_pixel_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.red_in(red_in),
		.green_in(green_in),
		.blue_in(blue_in),
		.alpha_in(alpha_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.red_out(red_out),
		.green_out(green_out),
		.blue_out(blue_out),
		.alpha_out(alpha_out),
		.errors(errors),
		.pending(pending)
	);

	function automatic int draw_gap(input bit burst);
		return burst ? 0 : $urandom_range(0, 6);
	endfunction

	task automatic send_word(input logic [1:0] act, input rgbap_pkg::chan_t r,
			input rgbap_pkg::chan_t g, input rgbap_pkg::chan_t b,
			input rgbap_pkg::chan_t a);
		int gap;
		gap = draw_gap(send_burst);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		action   <= act;
		red_in   <= r;
		green_in <= g;
		blue_in  <= b;
		alpha_in <= a;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_random();
		logic [1:0]       act;
		rgbap_pkg::chan_t a;
		rgbap_pkg::chan_t r;
		rgbap_pkg::chan_t g;
		rgbap_pkg::chan_t b;
		int               pick;
		pick = $urandom_range(0, 15);
		act = (pick == 15) ? ACT_SPARE : 2'(pick % 3);
		case ($urandom_range(0, 7))
			0: a = 8'd0;
			1: a = rgbap_pkg::CHAN_MAX;
			2: a = 8'd1;
			3: a = rgbap_pkg::CEIL_BIAS;
			default: a = 8'($urandom_range(0, 255));
		endcase
		// mostly premultiplied colour (not above alpha) for unpremultiply
		if (act == rgbap_pkg::ACT_UNPREM && $urandom_range(0, 3) != 0) begin
			r = 8'($urandom_range(0, a));
			g = 8'($urandom_range(0, a));
			b = 8'($urandom_range(0, a));
		end else begin
			r = 8'($urandom_range(0, 255));
			g = 8'($urandom_range(0, 255));
			b = 8'($urandom_range(0, 255));
		end
		send_word(act, r, g, b, a);
	endtask

	initial begin : sink
		int hold;
		forever begin
			@(negedge clk);
			if (sunk % 40 == 0)
				sink_burst = ($urandom_range(0, 3) == 0);
			if (sunk == 150 || sunk == 550)
				hold = LONG_HOLD;
			else
				hold = draw_gap(sink_burst);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			sunk++;
		end
	end

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		send_word(rgbap_pkg::ACT_FLOOR, 8'd0, 8'd255, 8'd128, 8'd0);
		send_word(rgbap_pkg::ACT_CEIL, 8'd255, 8'd0, 8'd77, 8'd0);
		send_word(rgbap_pkg::ACT_UNPREM, 8'd200, 8'd17, 8'd255, 8'd0);
		send_word(rgbap_pkg::ACT_FLOOR, 8'd255, 8'd1, 8'd99, 8'd255);
		send_word(rgbap_pkg::ACT_CEIL, 8'd0, 8'd254, 8'd33, 8'd255);
		send_word(rgbap_pkg::ACT_UNPREM, 8'd255, 8'd0, 8'd128, 8'd255);
		send_word(rgbap_pkg::ACT_FLOOR, 8'd255, 8'd0, 8'd1, 8'd1);
		send_word(rgbap_pkg::ACT_FLOOR, 8'd255, 8'd0, 8'd1, 8'd254);
		send_word(rgbap_pkg::ACT_FLOOR, 8'd255, 8'd128, 8'd1, 8'd128);
		send_word(rgbap_pkg::ACT_CEIL, 8'd255, 8'd0, 8'd1, 8'd1);
		send_word(rgbap_pkg::ACT_CEIL, 8'd255, 8'd0, 8'd1, 8'd254);
		send_word(rgbap_pkg::ACT_CEIL, 8'd255, 8'd128, 8'd1, 8'd128);
		send_word(rgbap_pkg::ACT_UNPREM, 8'd0, 8'd1, 8'd254, 8'd254);
		send_word(rgbap_pkg::ACT_UNPREM, 8'd0, 8'd1, 8'd127, 8'd128);
		send_word(rgbap_pkg::ACT_UNPREM, 8'd1, 8'd0, 8'd1, 8'd1);
		send_word(rgbap_pkg::ACT_UNPREM, 8'd255, 8'd2, 8'd200, 8'd1);
		send_word(rgbap_pkg::ACT_UNPREM, 8'd255, 8'd129, 8'd128, 8'd128);
		send_word(rgbap_pkg::ACT_UNPREM, 8'd255, 8'd255, 8'd255, 8'd254);
		send_word(ACT_SPARE, 8'd255, 8'd0, 8'd170, 8'd85);
		send_word(ACT_SPARE, 8'd85, 8'd170, 8'd0, 8'd0);
		send_word(ACT_SPARE, 8'd1, 8'd254, 8'd255, 8'd255);

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i % 64 == 0)
				send_burst = ($urandom_range(0, 3) == 0);
			send_random();
		end
		@(negedge clk);
		in_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (4 * rgbap_pkg::NUM_STAGES) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#400000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

[sim.f]
design/rgbap_pkg.sv
design/rgbap_ctl.sv
design/rgbap_chan.sv
design/rgba_alpha_premultiply_unit.sv
sim/rgbap_pixel_checker.sv
sim/tb.sv
